// ===== design/programmable_dfa_recognizer_macros.svh =====
// Assertion macros used by the recognizer control module.
`ifndef PROGRAMMABLE_DFA_RECOGNIZER_MACROS_SVH
`define PROGRAMMABLE_DFA_RECOGNIZER_MACROS_SVH

`ifndef SYNTH

`define PDFA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pdfa assertion failed");

`define PDFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pdfa assertion failed");

`else

`define PDFA_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define PDFA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/pdfa_pkg.sv =====
`default_nettype none

package pdfa_pkg;

    localparam int MAX_STATES  = 32;
    localparam int MAX_SYMBOLS = 16;

    localparam int STATE_W  = 5;
    localparam int SYM_W    = 4;
    localparam int CHAR_W   = 8;
    localparam int MASK_W   = 32;
    localparam int ASIZE_W  = 5;
    localparam int ADDR_W   = $clog2(MAX_STATES * MAX_SYMBOLS);
    localparam int CFG_IDX_W = 1;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;

    typedef enum logic [1:0] {
        REQ_WRITE_TRANS = 2'd0,
        REQ_WRITE_ALPHA = 2'd1,
        REQ_SYMBOL      = 2'd2,
        REQ_END         = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_STEPPED = 2'd0,
        ST_INVALID = 2'd1,
        ST_ACCEPT  = 2'd2,
        ST_REJECT  = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FINAL_MASK = 1'd0,
        CFG_ALPHA_SIZE = 1'd1
    } t_cfg_idx;

    typedef struct packed {
        logic take;
        logic look;
        logic emit;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic aborted;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// ===== design/programmable_dfa_recognizer.sv =====
// Table-driven DFA recognizer.
// The slave stream carries one request per transaction: tuser holds the request
// kind (write transition, write alphabet entry, input symbol, end of string) and
// tdata holds the selectors, next state and character. The master stream returns
// at most one result per request: tuser holds the status and tdata the from
// state, to state and matched alphabet index.
// Write requests are taken while idle and produce nothing. A symbol request passes
// from acceptance through a lookup state (alphabet compare with the transition RAM
// read) to a result state (result load); an end request goes from acceptance
// straight to the result state. Each request is finished before the next is taken,
// and that sequence through the registered-read transition RAM sets the rate. Symbols
// that arrive after an invalid symbol are taken and ignored until the end request.
// The user writes the final-state mask and alphabet size on the configuration port only
// while the block is idle; the block does not enforce this. Reset clears the registers,
// current state and abort flag; the tables are undefined until written. When the
// receiver stalls, the result register holds and the block still takes write requests
// and ignored symbols, but waits in its result stage before loading the next result.

`default_nettype none

module programmable_dfa_recognizer
    import pdfa_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // state_sel[4:0], symbol_sel[8:5], next_state[13:9], char_code[21:14], zero[23:22]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // req_type[1:0]
    input  wire logic [1:0]             s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // from_state[4:0], to_state[9:5], symbol_index[13:10], zero[15:14]
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
    // status[1:0]
    output logic      [1:0]             m_axis_tuser,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_addr,
    input  wire logic [MASK_W-1:0]      i_cfg_wdata
);

    t_cmd  cmd;
    t_stat stat;

    pdfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pdfa_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_data    (s_axis_tdata),
        .i_in_req     (s_axis_tuser),
        .o_out_data   (m_axis_tdata),
        .o_out_status (m_axis_tuser),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_cmd        (cmd),
        .o_stat       (stat)
    );

endmodule

`default_nettype wire

// ===== design/pdfa_ram.sv =====
`default_nettype none

module pdfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/pdfa_ctrl.sv =====
`default_nettype none

`include "programmable_dfa_recognizer_macros.svh"

module pdfa_ctrl
    import pdfa_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOOK = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   take;

    assign o_in_ready = (r_state == S_IDLE);
    assign take       = i_in_valid && o_in_ready;

    always_comb begin
        n_state    = r_state;
        o_cmd.take = 1'b0;
        o_cmd.look = 1'b0;
        o_cmd.emit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.take = take;
                if (take) begin
                    if (i_stat.req == REQ_END) begin
                        n_state = S_EMIT;
                    end else if (i_stat.req == REQ_SYMBOL && !i_stat.aborted) begin
                        n_state = S_LOOK;
                    end
                end
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `PDFA_ASSERT_NEXT(a_look_then_emit, i_clk, i_rst_n, r_state == S_LOOK, r_state == S_EMIT)
    `PDFA_ASSERT_SAME(a_emit_needs_slot, i_clk, i_rst_n, o_cmd.emit, i_stat.out_free)
    `PDFA_ASSERT_NEXT(a_end_goes_emit, i_clk, i_rst_n, take && i_stat.req == REQ_END, r_state == S_EMIT)
    `PDFA_ASSERT_SAME(a_one_cmd, i_clk, i_rst_n, 1'b1, $onehot0({o_cmd.take, o_cmd.look, o_cmd.emit}))

endmodule

`default_nettype wire

// ===== design/pdfa_dpath.sv =====
`default_nettype none

module pdfa_dpath
    import pdfa_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic [IN_TDATA_W-1:0]  i_in_data,
    input  wire logic [1:0]             i_in_req,
    output logic      [OUT_TDATA_W-1:0] o_out_data,
    output logic      [1:0]             o_out_status,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_addr,
    input  wire logic [MASK_W-1:0]      i_cfg_wdata,
    input  wire t_cmd                   i_cmd,
    output t_stat                       o_stat
);

    logic [STATE_W-1:0] in_state_sel;
    logic [SYM_W-1:0]   in_symbol_sel;
    logic [STATE_W-1:0] in_next_state;
    logic [CHAR_W-1:0]  in_char_code;

    assign in_state_sel  = i_in_data[4:0];
    assign in_symbol_sel = i_in_data[8:5];
    assign in_next_state = i_in_data[13:9];
    assign in_char_code  = i_in_data[21:14];

    logic [MASK_W-1:0]  r_final_mask;
    logic [ASIZE_W-1:0] r_alpha_size;
    logic [CHAR_W-1:0]  r_alpha [MAX_SYMBOLS];
    logic [STATE_W-1:0] r_cur_state;
    logic               r_aborted;
    logic [CHAR_W-1:0]  r_char;
    logic               r_is_end;
    logic [SYM_W-1:0]   r_k;
    logic               r_found;

    logic               r_out_valid;
    t_status            r_out_status;
    logic [STATE_W-1:0] r_out_from;
    logic [STATE_W-1:0] r_out_to;
    logic [SYM_W-1:0]   r_out_sym;

    logic [SYM_W-1:0]   match_k;
    logic               match_found;
    logic               tt_we;
    logic [ADDR_W-1:0]  tt_waddr;
    logic [ADDR_W-1:0]  tt_raddr;
    logic [STATE_W-1:0] tt_rdata;
    logic [STATE_W-1:0] step_to;
    t_status            end_status;

    // Lowest matching alphabet index wins, searched over the entries in use.
    always_comb begin
        match_k     = '0;
        match_found = 1'b0;
        for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
            if (i < int'(r_alpha_size) && r_alpha[i] == r_char) begin
                match_k     = SYM_W'(i);
                match_found = 1'b1;
            end
        end
    end

    assign tt_we = i_cmd.take && t_req'(i_in_req) == REQ_WRITE_TRANS
                   && int'(in_state_sel) < MAX_STATES && int'(in_symbol_sel) < MAX_SYMBOLS;
    assign tt_waddr = ADDR_W'(in_state_sel) * ADDR_W'(MAX_SYMBOLS) + ADDR_W'(in_symbol_sel);
    assign tt_raddr = ADDR_W'(r_cur_state) * ADDR_W'(MAX_SYMBOLS) + ADDR_W'(match_k);

    pdfa_ram #(
        .WIDTH (STATE_W),
        .DEPTH (MAX_STATES * MAX_SYMBOLS)
    ) u_trans_ram (
        .i_clk   (i_clk),
        .i_we    (tt_we),
        .i_waddr (tt_waddr),
        .i_wdata (in_next_state),
        .i_re    (i_cmd.look),
        .i_raddr (tt_raddr),
        .o_rdata (tt_rdata)
    );

    assign step_to    = (int'(r_cur_state) < MAX_STATES) ? tt_rdata : '0;
    assign end_status = (!r_aborted && r_final_mask[r_cur_state]) ? ST_ACCEPT : ST_REJECT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_final_mask <= '0;
            r_alpha_size <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_FINAL_MASK: r_final_mask <= i_cfg_wdata;
                CFG_ALPHA_SIZE: r_alpha_size <= i_cfg_wdata[ASIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && t_req'(i_in_req) == REQ_WRITE_ALPHA
                && int'(in_symbol_sel) < MAX_SYMBOLS) begin
            r_alpha[in_symbol_sel] <= in_char_code;
        end
        if (i_cmd.take) begin
            r_char   <= in_char_code;
            r_is_end <= (t_req'(i_in_req) == REQ_END);
        end
        if (i_cmd.look) begin
            r_k     <= match_k;
            r_found <= match_found;
        end
        if (i_cmd.emit) begin
            if (r_is_end) begin
                r_out_status <= end_status;
                r_out_from   <= r_cur_state;
                r_out_to     <= '0;
                r_out_sym    <= '0;
            end else if (!r_found) begin
                r_out_status <= ST_INVALID;
                r_out_from   <= r_cur_state;
                r_out_to     <= r_cur_state;
                r_out_sym    <= '0;
            end else begin
                r_out_status <= ST_STEPPED;
                r_out_from   <= r_cur_state;
                r_out_to     <= step_to;
                r_out_sym    <= r_k;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_state <= '0;
            r_aborted   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                if (r_is_end) begin
                    r_cur_state <= '0;
                    r_aborted   <= 1'b0;
                end else if (!r_found) begin
                    r_aborted <= 1'b1;
                end else begin
                    r_cur_state <= step_to;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.req      = t_req'(i_in_req);
    assign o_stat.aborted  = r_aborted;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_data   = {2'b00, r_out_sym, r_out_to, r_out_from};

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench
    import pdfa_pkg::*;
();

    typedef struct packed {
        t_status     status;
        logic [4:0]  from_state;
        logic [4:0]  to_state;
        logic [3:0]  symbol_index;
    } t_dfa_step;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]             s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [1:0]             m_axis_tuser;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_addr = '0;
    logic [MASK_W-1:0]      i_cfg_wdata = '0;

    logic [31:0] accept_mask = '0;
    logic [4:0]  alpha_count = '0;
    logic [4:0]  dfa_state = '0;
    logic        string_dead = 1'b0;
    logic [4:0]  next_tab [MAX_STATES*MAX_SYMBOLS];
    bit          tab_set [MAX_STATES*MAX_SYMBOLS];
    logic [7:0]  alphabet [MAX_SYMBOLS];

    t_dfa_step awaited_steps[$];
    int        useful_items = 0;
    int        failures = 0;
    bit        gaps_on = 1'b0;

    always #5 i_clk = ~i_clk;

    programmable_dfa_recognizer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    function automatic int find_symbol(logic [7:0] ch);
        int lim;
        lim = (alpha_count > MAX_SYMBOLS) ? MAX_SYMBOLS : alpha_count;
        for (int k = 0; k < lim; k++) begin
            if (alphabet[k] == ch) return k;
        end
        return -1;
    endfunction

    function automatic bit step_dfa(t_req req, logic [4:0] ssel, logic [3:0] ysel,
                                    logic [4:0] nxt, logic [7:0] ch);
        t_dfa_step r;
        int        k;
        logic [4:0] to;
        case (req)
            REQ_WRITE_TRANS: begin
                next_tab[{ssel, ysel}] = nxt;
                tab_set[{ssel, ysel}] = 1'b1;
                return 1'b1;
            end
            REQ_WRITE_ALPHA: begin
                alphabet[ysel] = ch;
                return 1'b1;
            end
            REQ_SYMBOL: begin
                if (string_dead) return 1'b0;
                k = find_symbol(ch);
                if (k < 0) begin
                    string_dead = 1'b1;
                    r = '{status: ST_INVALID, from_state: dfa_state, to_state: dfa_state,
                          symbol_index: 4'd0};
                end else begin
                    to = next_tab[{dfa_state, k[3:0]}];
                    r = '{status: ST_STEPPED, from_state: dfa_state, to_state: to,
                          symbol_index: k[3:0]};
                    dfa_state = to;
                end
                awaited_steps.push_back(r);
                return 1'b1;
            end
            default: begin
                r = '{status: (!string_dead && accept_mask[dfa_state]) ? ST_ACCEPT : ST_REJECT,
                      from_state: dfa_state, to_state: 5'd0, symbol_index: 4'd0};
                awaited_steps.push_back(r);
                dfa_state = 5'd0;
                string_dead = 1'b0;
                return 1'b1;
            end
        endcase
    endfunction

    task automatic push_request(t_req req, logic [4:0] ssel, logic [3:0] ysel,
                                logic [4:0] nxt, logic [7:0] ch);
        @(negedge i_clk);
        while (gaps_on && $urandom_range(99) < 9) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= req;
        s_axis_tdata <= {2'b00, ch, nxt, ysel, ssel};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        if (step_dfa(req, ssel, ysel, nxt, ch)) useful_items++;
    endtask

    task automatic send_symbol(logic [7:0] ch);
        int k;
        k = find_symbol(ch);
        if (!string_dead && k >= 0 && !tab_set[{dfa_state, k[3:0]}]) begin
            push_request(REQ_WRITE_TRANS, dfa_state, k[3:0], 5'($urandom_range(31)),
                         8'($urandom_range(255)));
        end
        push_request(REQ_SYMBOL, 5'($urandom_range(31)), 4'($urandom_range(15)),
                     5'($urandom_range(31)), ch);
    endtask

    task automatic send_end();
        push_request(REQ_END, 5'($urandom_range(31)), 4'($urandom_range(15)),
                     5'($urandom_range(31)), 8'($urandom_range(255)));
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (awaited_steps.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_register(t_cfg_idx idx, logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_FINAL_MASK: accept_mask = value;
            default:        alpha_count = value[4:0];
        endcase
    endtask

    task automatic test_reset_state();
        send_symbol(8'($urandom_range(255)));
        send_symbol(8'($urandom_range(255)));
        send_end();
        send_end();
    endtask

    task automatic test_directed_paths();
        logic [7:0] chars [16];
        for (int k = 0; k < 16; k++) chars[k] = 8'(8'h41 + k);
        chars[0] = 8'h00;
        chars[15] = 8'hFF;
        chars[7] = chars[3];
        for (int k = 0; k < 16; k++) begin
            push_request(REQ_WRITE_ALPHA, 5'($urandom_range(31)), k[3:0],
                         5'($urandom_range(31)), chars[k]);
        end
        wait_idle();
        write_register(CFG_ALPHA_SIZE, 32'd16);
        write_register(CFG_FINAL_MASK, 32'hFFFF_FFFF);
        push_request(REQ_WRITE_TRANS, 5'd0, 4'd0, 5'd31, 8'($urandom_range(255)));
        push_request(REQ_WRITE_TRANS, 5'd31, 4'd15, 5'd17, 8'($urandom_range(255)));
        push_request(REQ_WRITE_TRANS, 5'd17, 4'd3, 5'd0, 8'($urandom_range(255)));
        send_symbol(8'h00);
        send_symbol(8'hFF);
        send_symbol(chars[3]);
        send_end();
        send_symbol(8'h80);
        send_symbol(8'h00);
        send_end();
        send_symbol(8'h00);
        send_end();
    endtask

    task automatic test_oversized_alphabet();
        wait_idle();
        write_register(CFG_ALPHA_SIZE, 32'd31);
        write_register(CFG_FINAL_MASK, 32'h0);
        send_symbol(8'hFF);
        send_end();
        wait_idle();
        write_register(CFG_ALPHA_SIZE, 32'd1);
        send_symbol(8'hFF);
        send_end();
    endtask

    task automatic test_random_strings(logic [31:0] mask, logic [4:0] size, int n_items,
                                       bit with_gaps);
        int start;
        int roll;
        int len;
        int lim;
        logic [7:0] ch;
        wait_idle();
        write_register(CFG_FINAL_MASK, mask);
        write_register(CFG_ALPHA_SIZE, {27'd0, size});
        gaps_on = with_gaps;
        start = useful_items;
        while (useful_items - start < n_items) begin
            roll = $urandom_range(99);
            lim = (alpha_count > MAX_SYMBOLS) ? MAX_SYMBOLS : alpha_count;
            if (roll < 8) begin
                push_request(REQ_WRITE_TRANS, 5'($urandom_range(31)), 4'($urandom_range(15)),
                             5'($urandom_range(31)), 8'($urandom_range(255)));
            end else if (roll < 12) begin
                push_request(REQ_WRITE_ALPHA, 5'($urandom_range(31)), 4'($urandom_range(15)),
                             5'($urandom_range(31)), 8'($urandom_range(255)));
            end else begin
                len = $urandom_range(10);
                repeat (len) begin
                    if (lim > 0 && $urandom_range(99) < 92) begin
                        ch = alphabet[4'($urandom_range(lim - 1))];
                    end else begin
                        ch = 8'($urandom_range(255));
                    end
                    send_symbol(ch);
                end
                send_end();
            end
        end
    endtask

    always @(negedge i_clk) begin
        m_axis_tready <= !gaps_on || ($urandom_range(99) >= 9);
    end

    always @(posedge i_clk) begin
        t_dfa_step want;
        if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            if (awaited_steps.size() == 0) begin
                $error("result with no request pending: status %0d tdata %h",
                       m_axis_tuser, m_axis_tdata);
                failures++;
            end else begin
                want = awaited_steps.pop_front();
                if (m_axis_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                    failures++;
                end
                if (m_axis_tdata[4:0] !== want.from_state) begin
                    $error("from_state: expected %0d, got %0d", want.from_state,
                           m_axis_tdata[4:0]);
                    failures++;
                end
                if (m_axis_tdata[9:5] !== want.to_state) begin
                    $error("to_state: expected %0d, got %0d", want.to_state, m_axis_tdata[9:5]);
                    failures++;
                end
                if (m_axis_tdata[13:10] !== want.symbol_index) begin
                    $error("symbol_index: expected %0d, got %0d", want.symbol_index,
                           m_axis_tdata[13:10]);
                    failures++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_directed_paths();
        test_oversized_alphabet();
        test_random_strings(32'hFFFF_FFFF, 5'd16, 300, 1'b0);
        test_random_strings($urandom, 5'd1, 300, 1'b1);
        test_random_strings(32'h0, 5'd31, 300, 1'b1);
        test_random_strings($urandom, 5'($urandom_range(2, 15)), 300, 1'b1);
        test_random_strings(32'h8000_0001, 5'd16, 300, 1'b1);
        test_random_strings($urandom, 5'($urandom_range(1, 16)), 300, 1'b1);
        wait_idle();
        if (failures == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
